// ===== hw/rtl/tda_pkg.sv =====
// ----------------------------------------------------------------------------
// tda_pkg
// shared constants and command/status types for the trip distance accumulator
// ----------------------------------------------------------------------------
package tda_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int ACC_WIDTH_DEF   = 48;
  localparam int CNT_WIDTH       = 32;

  localparam logic [1:0] ACT_FIX   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // distance selectors for the shared root unit
  localparam logic [1:0] DSEL_START = 2'd0;
  localparam logic [1:0] DSEL_PREV  = 2'd1;
  localparam logic [1:0] DSEL_STOP  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       sq_start;
    logic [1:0] sq_sel;
    logic       sq_step;
    logic       acc_start;
    logic       acc_prev;
    logic       commit;
    logic       div_start;
    logic       div_step;
    logic       stop_dist;
    logic       out_load;
  } tda_cmd_t;

  typedef struct packed {
    logic sq_done;
    logic div_done;
    logic active;
  } tda_sts_t;

endpackage

// ===== hw/rtl/tda_datapath.sv =====
// ----------------------------------------------------------------------------
// tda_datapath
// position registers, shared iterative root unit, saturating accumulators,
// restoring divider and output register
// ----------------------------------------------------------------------------
module tda_datapath #(
  parameter int COORD_WIDTH = tda_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = tda_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tda_pkg::tda_cmd_t            cmd,
  output tda_pkg::tda_sts_t            sts,
  input  logic [1:0]                   in_action,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  output logic                         out_trip_done,
  output logic [ACC_WIDTH-1:0]         out_path_length,
  output logic [ACC_WIDTH-1:0]         out_start_distance_sum,
  output logic [31:0]                  out_fix_count,
  output logic [COORD_WIDTH:0]         out_average_start_distance,
  output logic                         out_average_valid,
  output logic [COORD_WIDTH:0]         out_stop_to_start_distance,
  output logic signed [COORD_WIDTH-1:0] out_stop_x,
  output logic signed [COORD_WIDTH-1:0] out_stop_y
);

  localparam int DW  = COORD_WIDTH + 1;   // difference / distance width
  localparam int SW  = 2 * DW + 2;        // sum of squares width, even for aligned bit pairs
  localparam int RW  = DW + 1;            // root width
  localparam int RCW = $clog2(RW + 1);
  localparam int CW  = tda_pkg::CNT_WIDTH;
  localparam int DCW = $clog2(ACC_WIDTH + 1);
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [DW-1:0] DIST_MAX = '1;

  logic [1:0]                   act_r;
  logic signed [COORD_WIDTH-1:0] x_r, y_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r, end_x_r, end_y_r;
  logic started_r, finished_r;
  logic [ACC_WIDTH-1:0] path_r, sdist_r;
  logic [CW-1:0] cnt_r;

  // root unit
  logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0] adx, ady;
  logic [SW-1:0] sq_nxt;
  logic [SW+1:0] rem_r, rem_nxt, trial;
  logic [SW-1:0] op_r;
  logic [RW-1:0] root_r;
  logic [RCW-1:0] sq_cnt_r;
  logic [DW-1:0] root_d;

  always_comb begin
    ax = x_r; ay = y_r; bx = start_x_r; by = start_y_r;
    case (cmd.sq_sel)
      tda_pkg::DSEL_PREV: begin bx = prev_x_r; by = prev_y_r; end
      tda_pkg::DSEL_STOP: begin ax = end_x_r; ay = end_y_r; end
      default: ;
    endcase
    ddx = DW'(ax) - DW'(bx);
    ddy = DW'(ay) - DW'(by);
    adx = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
    ady = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
    sq_nxt = SW'(adx * adx) + SW'(ady * ady);
  end

  // two bits of the radicand per step, one root bit
  always_comb begin
    rem_nxt = {rem_r[SW-1:0], op_r[SW-1 -: 2]};
    trial   = {root_r, 2'b01};
    if (rem_nxt >= trial) rem_nxt = rem_nxt - trial;
  end
  assign root_d = root_r[DW-1:0];

  // divider
  logic [ACC_WIDTH-1:0] quo_r;
  logic [CW:0] drem_r, drem_sh;
  logic [DCW-1:0] div_cnt_r;
  assign drem_sh = {drem_r[CW-1:0], quo_r[ACC_WIDTH-1]};

  logic [ACC_WIDTH:0] sum_start, sum_prev;
  logic [DW-1:0] s2s_r;

  assign sum_start = {1'b0, sdist_r} + (ACC_WIDTH+1)'(root_d);
  assign sum_prev  = {1'b0, path_r} + (ACC_WIDTH+1)'(root_d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0; finished_r <= 1'b0;
      prev_x_r <= '0; prev_y_r <= '0; start_x_r <= '0; start_y_r <= '0;
      end_x_r <= '0; end_y_r <= '0;
      path_r <= '0; sdist_r <= '0; cnt_r <= '0;
      sq_cnt_r <= '0; div_cnt_r <= '0;
    end else begin
      if (cmd.load_in) begin
        act_r <= in_action; x_r <= in_pos_x; y_r <= in_pos_y;
      end
      if (cmd.sq_start) begin
        op_r <= sq_nxt; rem_r <= '0; root_r <= '0; sq_cnt_r <= RCW'(RW);
      end else if (cmd.sq_step && sq_cnt_r != '0) begin
        op_r <= {op_r[SW-3:0], 2'b00};
        rem_r <= rem_nxt;
        root_r <= {root_r[RW-2:0], (rem_nxt != {rem_r[SW-1:0], op_r[SW-1 -: 2]}) ||
                   ({rem_r[SW-1:0], op_r[SW-1 -: 2]} == trial)};
        sq_cnt_r <= sq_cnt_r - 1'b1;
      end
      if (cmd.acc_start) begin
        sdist_r <= sum_start[ACC_WIDTH] ? ACC_MAX : sum_start[ACC_WIDTH-1:0];
      end
      if (cmd.acc_prev) begin
        path_r <= sum_prev[ACC_WIDTH] ? ACC_MAX : sum_prev[ACC_WIDTH-1:0];
      end
      // a finished trip ignores every later fix
      if (cmd.commit && !finished_r) begin
        if (started_r) begin
          if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
          if (act_r == tda_pkg::ACT_STOP) begin
            finished_r <= 1'b1; end_x_r <= x_r; end_y_r <= y_r;
          end
        end
        if (act_r == tda_pkg::ACT_START) begin
          started_r <= 1'b1; start_x_r <= x_r; start_y_r <= y_r;
        end
        prev_x_r <= x_r; prev_y_r <= y_r;
      end
      if (cmd.stop_dist) s2s_r <= root_d;
      if (cmd.div_start) begin
        quo_r <= sdist_r; drem_r <= '0; div_cnt_r <= DCW'(ACC_WIDTH);
      end else if (cmd.div_step && div_cnt_r != '0) begin
        if (drem_sh >= {1'b0, cnt_r}) begin
          drem_r <= drem_sh - {1'b0, cnt_r};
          quo_r  <= {quo_r[ACC_WIDTH-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          quo_r  <= {quo_r[ACC_WIDTH-2:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_trip_done <= finished_r;
      out_path_length <= path_r;
      out_start_distance_sum <= sdist_r;
      out_fix_count <= cnt_r;
      out_average_valid <= cnt_r != '0;
      if (cnt_r == '0) out_average_start_distance <= '0;
      else if (quo_r > ACC_WIDTH'(DIST_MAX)) out_average_start_distance <= DIST_MAX;
      else out_average_start_distance <= quo_r[DW-1:0];
      out_stop_to_start_distance <= s2s_r;
      out_stop_x <= end_x_r;
      out_stop_y <= end_y_r;
    end
  end

  assign sts.sq_done  = (sq_cnt_r == '0);
  assign sts.div_done = (div_cnt_r == '0);
  assign sts.active   = started_r & ~finished_r;

endmodule

// ===== hw/rtl/tda_ctrl.sv =====
// ----------------------------------------------------------------------------
// tda_ctrl
// sequencer: accept beat, up to three roots, accumulate, divide, present result
// ----------------------------------------------------------------------------
module tda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tda_pkg::tda_cmd_t cmd,
  input  tda_pkg::tda_sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RS_GO  = 4'd1;
  localparam logic [3:0] S_RS     = 4'd2;
  localparam logic [3:0] S_RP_GO  = 4'd3;
  localparam logic [3:0] S_RP     = 4'd4;
  localparam logic [3:0] S_COMMIT = 4'd5;
  localparam logic [3:0] S_RE_GO  = 4'd6;
  localparam logic [3:0] S_RE     = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd.sq_step = 1'b1;
    cmd.div_step = 1'b1;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load_in = 1'b1; state_nxt = S_RS_GO;
      end
      S_RS_GO: begin
        if (sts.active) begin
          cmd.sq_start = 1'b1; cmd.sq_sel = tda_pkg::DSEL_START; state_nxt = S_RS;
        end else state_nxt = S_COMMIT;
      end
      S_RS: if (sts.sq_done) begin cmd.acc_start = 1'b1; state_nxt = S_RP_GO; end
      S_RP_GO: begin
        cmd.sq_start = 1'b1; cmd.sq_sel = tda_pkg::DSEL_PREV; state_nxt = S_RP;
      end
      S_RP: if (sts.sq_done) begin cmd.acc_prev = 1'b1; state_nxt = S_COMMIT; end
      S_COMMIT: begin
        cmd.commit = 1'b1; state_nxt = S_RE_GO;
      end
      S_RE_GO: begin
        cmd.sq_start = 1'b1; cmd.sq_sel = tda_pkg::DSEL_STOP;
        cmd.div_start = 1'b1; state_nxt = S_RE;
      end
      S_RE: if (sts.sq_done) begin cmd.stop_dist = 1'b1; state_nxt = S_DIV; end
      S_DIV: if (sts.div_done && !ovalid_nxt) begin
        cmd.out_load = 1'b1; ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== hw/rtl/trip_distance_accumulator.sv =====
// ----------------------------------------------------------------------------
// trip_distance_accumulator
// path length and start distance statistics over a stream of position fixes
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action, pos_x, pos_y
//  out_    | output    | out_valid/out_stall| trip totals, stop point, distances
//
//  during a trip a fix takes three passes of the one-bit-per-cycle root unit and
//  the tail of the 48-step divider, which starts with the last root; outside a
//  trip, only the last root pass and the divider. reset is synchronous and
//  clears all trip state. the result register holds a beat while out_stall
//  is high; the next fix is taken while a result still waits, but is not
//  presented until the previous beat leaves.
module trip_distance_accumulator #(
  parameter int COORD_WIDTH = tda_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = tda_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trip_done,
  output logic [ACC_WIDTH-1:0]          out_path_length,
  output logic [ACC_WIDTH-1:0]          out_start_distance_sum,
  output logic [31:0]                   out_fix_count,
  output logic [COORD_WIDTH:0]          out_average_start_distance,
  output logic                          out_average_valid,
  output logic [COORD_WIDTH:0]          out_stop_to_start_distance,
  output logic signed [COORD_WIDTH-1:0] out_stop_x,
  output logic signed [COORD_WIDTH-1:0] out_stop_y
);

  tda_pkg::tda_cmd_t cmd;
  tda_pkg::tda_sts_t sts;

  tda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  tda_datapath #(.COORD_WIDTH(COORD_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_trip_done(out_trip_done), .out_path_length(out_path_length),
    .out_start_distance_sum(out_start_distance_sum), .out_fix_count(out_fix_count),
    .out_average_start_distance(out_average_start_distance),
    .out_average_valid(out_average_valid),
    .out_stop_to_start_distance(out_stop_to_start_distance),
    .out_stop_x(out_stop_x), .out_stop_y(out_stop_y)
  );

  // a result is only loaded when the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.out_load) else $error("result overwritten");

  // the trip is never reported done before a fix was counted
  a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trip_done) |-> (out_fix_count != '0)) else $error("done without fixes");

  // average is valid exactly when count is nonzero
  a_avg_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average_valid == (out_fix_count != '0)))
    else $error("average valid mismatch");

endmodule
